// ----- design/bmdc_pkg.sv -----
// Shared types and constants of the bitmask dictionary code compressor.
// No dependencies; imported by the entry matcher and the top level.
package bmdc_pkg;

  // Command codes carried by the opcode field
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // Three-bit format prefixes of the emitted codes
  localparam logic [2:0] KIND_RAW      = 3'b000;
  localparam logic [2:0] KIND_RUN      = 3'b001;
  localparam logic [2:0] KIND_SPAN     = 3'b010;
  localparam logic [2:0] KIND_ONE      = 3'b011;
  localparam logic [2:0] KIND_TWO_ADJ  = 3'b100;
  localparam logic [2:0] KIND_FOUR_ADJ = 3'b101;
  localparam logic [2:0] KIND_TWO_ANY  = 3'b110;
  localparam logic [2:0] KIND_EXACT    = 3'b111;

  // Output field widths
  localparam int CODE_W  = 35;
  localparam int LEN_W   = 6;
  localparam int LOC_W   = 5;
  localparam int MASK_W  = 4;
  localparam int IDX_W   = 4;
  localparam int RCODE_W = 3;

  // Fixed code lengths
  localparam logic [LEN_W-1:0] LEN_EXACT = 6'd7;
  localparam logic [LEN_W-1:0] LEN_LOC   = 6'd12;
  localparam logic [LEN_W-1:0] LEN_SPAN  = 6'd16;
  localparam logic [LEN_W-1:0] LEN_TWO   = 6'd17;
  localparam logic [LEN_W-1:0] LEN_RUN   = 6'd6;

  // Format rank: lower value wins, ties go to the lower entry
  typedef enum logic [2:0] {
    FMT_EXACT    = 3'd0,
    FMT_ONE      = 3'd1,
    FMT_TWO_ADJ  = 3'd2,
    FMT_FOUR_ADJ = 3'd3,
    FMT_SPAN     = 3'd4,
    FMT_TWO_ANY  = 3'd5,
    FMT_NONE     = 3'd6
  } fmt_e;

  // Classification of one word against one dictionary entry
  typedef struct packed {
    fmt_e              fmt;
    logic [LOC_W-1:0]  loc;
    logic [LOC_W-1:0]  loc2;
    logic [MASK_W-1:0] mask;
  } match_t;

endpackage

// ----- design/bmdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the dictionary of the compressor.
module bmdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/bmdc_match.sv -----
// Classifies the difference between an input word and one dictionary entry.
// Depends on bmdc_pkg for the format rank and the match struct.
module bmdc_match #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WORD_BITS-1:0] entry_i,
  output bmdc_pkg::match_t     match_o
);
  import bmdc_pkg::*;

  localparam int PW = $clog2(WORD_BITS + 1);
  localparam int HW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] diff;
  logic [PW-1:0]        pop;
  logic [HW-1:0]        hi;
  logic [HW-1:0]        lo;
  logic [HW-1:0]        span;
  logic [MASK_W-1:0]    mask;
  logic                 nz;

  assign diff = word_i ^ entry_i;
  assign nz   = |diff;
  assign pop  = PW'($countones(diff));

  // Locate highest and lowest differing bits
  always_comb begin
    hi = '0;
    lo = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (diff[i]) begin
        hi = HW'(i);
      end
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (diff[i]) begin
        lo = HW'(i);
      end
    end
  end

  assign span = hi - lo;

  // Take the four bits starting at the highest differing bit
  always_comb begin
    mask = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (int'(hi) >= k) begin
        mask[MASK_W-1-k] = diff[hi - HW'(k)];
      end
    end
  end

  // Pick the best format this entry allows
  always_comb begin
    match_o.loc  = LOC_W'(WORD_BITS - 1 - int'(hi));
    match_o.loc2 = LOC_W'(WORD_BITS - 1 - int'(lo));
    match_o.mask = mask;
    if (!nz) begin
      match_o.fmt = FMT_EXACT;
    end else if (pop == PW'(1)) begin
      match_o.fmt = FMT_ONE;
    end else if (pop == PW'(2) && span == HW'(1)) begin
      match_o.fmt = FMT_TWO_ADJ;
    end else if (pop == PW'(4) && span == HW'(3)) begin
      match_o.fmt = FMT_FOUR_ADJ;
    end else if (span <= HW'(3)) begin
      match_o.fmt = FMT_SPAN;
    end else if (pop == PW'(2)) begin
      match_o.fmt = FMT_TWO_ANY;
    end else begin
      match_o.fmt = FMT_NONE;
    end
  end

endmodule

// ----- design/bitmask_dictionary_code_compressor.sv -----
// Bitmask dictionary code compressor. Load all DICT_ENTRIES dictionary slots first, then send
// words to encode; repeats of the previous word are counted (up to MAX_RUN) and leave as one
// run code, and a flush sends a pending run. A load, a counted repeat or a flush with no run
// pending leaves the input free the next cycle; a flush that emits first passes the run beat,
// which waits while the output stalls. An encoded word passes the run beat if a run is pending,
// then the scan, a wait and the code beat, which also waits on the output. The single entry
// matcher scans the dictionary RAM one entry per cycle. The input is not ready while an item is at work.
module bitmask_dictionary_code_compressor #(
  parameter int DICT_ENTRIES = 16,
  parameter int WORD_BITS    = 32,
  parameter int MAX_RUN      = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       opcode_i,
  input  logic [31:0]                      word_i,
  input  logic [3:0]                       dict_slot_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bmdc_pkg::CODE_W-1:0]      code_o,
  output logic [bmdc_pkg::LEN_W-1:0]       code_len_o,
  output logic [2:0]                       code_kind_o,
  output logic                             last_o
);
  import bmdc_pkg::*;

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int RW = $clog2(MAX_RUN + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_SCAN = 5'b00100,
    S_WAIT = 5'b01000,
    S_CODE = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [WORD_BITS-1:0] prev_word_q, prev_word_d;
  logic                 prev_valid_q, prev_valid_d;
  logic [RW-1:0]        run_count_q, run_count_d;
  logic                 run_last_q, run_last_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic                 eval_valid_q, eval_valid_d;
  logic [AW-1:0]        eval_idx_q, eval_idx_d;
  fmt_e                 best_fmt_q, best_fmt_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  match_t               best_q, best_d;
  logic                 out_valid_q, out_valid_d;
  logic [CODE_W-1:0]    code_q, code_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [2:0]           kind_q, kind_d;
  logic                 last_q, last_d;

  logic                 in_fire;
  logic                 out_free;
  logic [WORD_BITS-1:0] in_word;
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_rdata;
  match_t               match;
  logic [IDX_W-1:0]     best_idx_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_word    = word_i[WORD_BITS-1:0];
  assign ram_we     = in_fire && (opcode_i == OP_LOAD) && (int'(dict_slot_i) < DICT_ENTRIES);
  assign best_idx_ext = IDX_W'(best_idx_q);

  bmdc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DICT_ENTRIES)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (dict_slot_i[AW-1:0]),
    .wdata_i (in_word),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  bmdc_match #(
    .WORD_BITS (WORD_BITS)
  ) u_match (
    .word_i  (word_q),
    .entry_i (ram_rdata),
    .match_o (match)
  );

  // Sequencer: accept, optional run beat, dictionary scan, wait, code beat
  always_comb begin
    state_d      = state_q;
    prev_word_d  = prev_word_q;
    prev_valid_d = prev_valid_q;
    run_count_d  = run_count_q;
    run_last_d   = run_last_q;
    word_d       = word_q;
    addr_d       = addr_q;
    eval_valid_d = 1'b0;
    eval_idx_d   = eval_idx_q;
    best_fmt_d   = best_fmt_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    code_d       = code_q;
    len_d        = len_q;
    kind_d       = kind_q;
    last_d       = last_q;

    // Keep the best match seen so far
    if (eval_valid_q && (match.fmt < best_fmt_q)) begin
      best_fmt_d = match.fmt;
      best_idx_d = eval_idx_q;
      best_d     = match;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          word_d   = in_word;
          addr_d   = '0;
          best_fmt_d = FMT_NONE;
          case (opcode_i)
            OP_ENCODE: begin
              if (prev_valid_q && (in_word == prev_word_q) &&
                  (run_count_q < RW'(MAX_RUN))) begin
                run_count_d = run_count_q + RW'(1);
              end else begin
                prev_word_d  = in_word;
                prev_valid_d = 1'b1;
                run_last_d   = 1'b0;
                state_d      = (run_count_q != '0) ? S_RUN : S_SCAN;
              end
            end
            OP_FLUSH: begin
              run_last_d = 1'b1;
              if (run_count_q != '0) begin
                state_d = S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          code_d      = CODE_W'({KIND_RUN, RCODE_W'(run_count_q - RW'(1))});
          len_d       = LEN_RUN;
          kind_d      = KIND_RUN;
          last_d      = run_last_q;
          run_count_d = '0;
          state_d     = run_last_q ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        eval_valid_d = 1'b1;
        eval_idx_d   = addr_q;
        if (addr_q == AW'(DICT_ENTRIES - 1)) begin
          state_d = S_WAIT;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      S_WAIT: begin
        state_d = S_CODE;
      end
      S_CODE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          state_d     = S_IDLE;
          case (best_fmt_q)
            FMT_EXACT: begin
              code_d = CODE_W'({KIND_EXACT, best_idx_ext});
              len_d  = LEN_EXACT;
              kind_d = KIND_EXACT;
            end
            FMT_ONE: begin
              code_d = CODE_W'({KIND_ONE, best_q.loc, best_idx_ext});
              len_d  = LEN_LOC;
              kind_d = KIND_ONE;
            end
            FMT_TWO_ADJ: begin
              code_d = CODE_W'({KIND_TWO_ADJ, best_q.loc, best_idx_ext});
              len_d  = LEN_LOC;
              kind_d = KIND_TWO_ADJ;
            end
            FMT_FOUR_ADJ: begin
              code_d = CODE_W'({KIND_FOUR_ADJ, best_q.loc, best_idx_ext});
              len_d  = LEN_LOC;
              kind_d = KIND_FOUR_ADJ;
            end
            FMT_SPAN: begin
              code_d = CODE_W'({KIND_SPAN, best_q.loc, best_q.mask, best_idx_ext});
              len_d  = LEN_SPAN;
              kind_d = KIND_SPAN;
            end
            FMT_TWO_ANY: begin
              code_d = CODE_W'({KIND_TWO_ANY, best_q.loc, best_q.loc2, best_idx_ext});
              len_d  = LEN_TWO;
              kind_d = KIND_TWO_ANY;
            end
            default: begin
              code_d = CODE_W'(word_q);
              len_d  = LEN_W'(3 + WORD_BITS);
              kind_d = KIND_RAW;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_word_q  <= '0;
      prev_valid_q <= 1'b0;
      run_count_q  <= '0;
      eval_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_word_q  <= prev_word_d;
      prev_valid_q <= prev_valid_d;
      run_count_q  <= run_count_d;
      eval_valid_q <= eval_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    run_last_q <= run_last_d;
    word_q     <= word_d;
    addr_q     <= addr_d;
    eval_idx_q <= eval_idx_d;
    best_fmt_q <= best_fmt_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    code_q     <= code_d;
    len_q      <= len_d;
    kind_q     <= kind_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;
  assign code_len_o  = len_q;
  assign code_kind_o = kind_q;
  assign last_o      = last_q;

endmodule
